// ===== design/lsrd_pkg.sv =====
package lsrd_pkg;

  localparam int unsigned STEP_W   = 10;
  localparam int unsigned CLU_W    = 7;
  localparam int unsigned NUM_W    = 11;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned RANGE_W  = 13;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned MAX_STEP_DEF = 768;

  localparam logic [STEP_W-1:0] START_RST = 10'd43;
  localparam logic [STEP_W-1:0] END_RST   = 10'd725;
  localparam logic [CLU_W-1:0]  CLU_RST   = 7'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_START_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_STEP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT = 2'd2;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_G     = 8'h47;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_DIFF  = 8'h20;

  localparam logic [11:0]        RANGE_MIN  = 12'd20;
  localparam logic [RANGE_W-1:0] RANGE_NONE = 13'd4096;
  localparam logic [LEN_W-1:0]   LEN_MAX    = 4'd15;

  typedef enum logic [1:0] {
    PH_ECHO   = 2'd0,
    PH_STATUS = 2'd1,
    PH_DATA   = 2'd2
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_RANGE      = 2'd0,
    KIND_DONE       = 2'd1,
    KIND_ECHO_ERR   = 2'd2,
    KIND_STATUS_ERR = 2'd3
  } kind_t;

  typedef logic [3:0][3:0] digits_t;

  typedef struct packed {
    digits_t start_d;
    digits_t end_d;
    digits_t clu_d;
  } echo_cfg_t;

  // Decimal digits of a value below 1024, using x/10 = (x*205)>>11.
  function automatic digits_t dec4(input logic [STEP_W-1:0] v);
    logic [17:0] p1;
    logic [6:0]  q1;
    logic [14:0] p2;
    logic [3:0]  q2;
    logic [11:0] p3;
    logic        q3;
    digits_t     d;
    p1 = 18'(v) * 18'd205;
    q1 = p1[17:11];
    p2 = 15'(q1) * 15'd205;
    q2 = p2[14:11];
    p3 = 12'(q2) * 12'd205;
    q3 = p3[11];
    d[0] = 4'(v - 10'(q1) * 10'd10);
    d[1] = 4'(q1 - 7'(q2) * 7'd10);
    d[2] = 4'(q2 - 4'(q3) * 4'd10);
    d[3] = {3'b000, q3};
    return d;
  endfunction

endpackage

// ===== design/lsrd_in_if.sv =====
interface lsrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== design/lsrd_out_if.sv =====
interface lsrd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [9:0]  slot;
  logic [12:0] range_mm;
  logic [9:0]  readings_filled;

  modport source (output valid, output kind, output slot, output range_mm,
                  output readings_filled, input ready);
  modport sink (input valid, input kind, input slot, input range_mm,
                input readings_filled, output ready);
endinterface

// ===== design/lsrd_cfg.sv =====
module lsrd_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lsrd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsrd_pkg::STEP_W-1:0]     cfg_wdata,
  output logic [lsrd_pkg::STEP_W-1:0]     start_step,
  output logic [lsrd_pkg::STEP_W-1:0]     end_step,
  output logic [lsrd_pkg::CLU_W-1:0]      cluster_count,
  output lsrd_pkg::echo_cfg_t             echo_cfg,
  output logic                            kick
);
  import lsrd_pkg::*;

  logic [STEP_W-1:0] start_r, end_r;
  logic [CLU_W-1:0]  clu_r;
  echo_cfg_t         echo_r;
  logic              kick_r;
  logic              hit;

  assign hit = cfg_we && (cfg_index == CFG_START_STEP || cfg_index == CFG_END_STEP ||
                          cfg_index == CFG_CLUSTER_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r        <= START_RST;
      end_r          <= END_RST;
      clu_r          <= CLU_RST;
      echo_r.start_d <= dec4(START_RST);
      echo_r.end_d   <= dec4(END_RST);
      echo_r.clu_d   <= dec4({3'b000, CLU_RST});
      kick_r         <= 1'b1;
    end else begin
      kick_r <= hit;
      if (cfg_we) begin
        if (cfg_index == CFG_START_STEP) begin
          start_r        <= cfg_wdata;
          echo_r.start_d <= dec4(cfg_wdata);
        end else if (cfg_index == CFG_END_STEP) begin
          end_r        <= cfg_wdata;
          echo_r.end_d <= dec4(cfg_wdata);
        end else if (cfg_index == CFG_CLUSTER_COUNT) begin
          clu_r        <= cfg_wdata[CLU_W-1:0];
          echo_r.clu_d <= dec4({3'b000, cfg_wdata[CLU_W-1:0]});
        end
      end
    end
  end

  assign start_step    = start_r;
  assign end_step      = end_r;
  assign cluster_count = clu_r;
  assign echo_cfg      = echo_r;
  assign kick          = kick_r;

endmodule

// ===== design/lsrd_div.sv =====
module lsrd_div #(
  parameter int unsigned MAX_STEP = lsrd_pkg::MAX_STEP_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lsrd_pkg::STEP_W-1:0] start_step,
  input  logic [lsrd_pkg::STEP_W-1:0] end_step,
  input  logic [lsrd_pkg::CLU_W-1:0]  cluster_count,
  output logic                        busy,
  output logic [lsrd_pkg::STEP_W-1:0] slot_total
);
  import lsrd_pkg::*;

  localparam logic [NUM_W-1:0] CAP = NUM_W'(MAX_STEP);

  logic [3:0]       cnt_r, cnt_nxt;
  logic [CLU_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [CLU_W-1:0] den_r, den_nxt;
  logic [CLU_W-1:0] den;
  logic [NUM_W-1:0] numer;
  logic [CLU_W:0]   shifted;
  logic             fits;

  assign den   = (cluster_count == '0) ? CLU_W'(1) : cluster_count;
  assign numer = (end_step > start_step) ?
                 NUM_W'({1'b0, end_step} - {1'b0, start_step} + NUM_W'(den) - NUM_W'(1)) :
                 '0;

  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign fits    = shifted >= {1'b0, den_r};

  always_comb begin
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    den_nxt = den_r;
    if (start) begin
      cnt_nxt = 4'(NUM_W);
      rem_nxt = '0;
      quo_nxt = numer;
      den_nxt = den;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 4'd1;
      rem_nxt = fits ? CLU_W'(shifted - {1'b0, den_r}) : shifted[CLU_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign busy       = cnt_r != '0;
  assign slot_total = (quo_r > CAP) ? CAP[STEP_W-1:0] : quo_r[STEP_W-1:0];

endmodule

// ===== design/lsrd_core.sv =====
module lsrd_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        hold,
  input  lsrd_pkg::echo_cfg_t         echo_cfg,
  input  logic [lsrd_pkg::STEP_W-1:0] slot_total,
  lsrd_in_if.sink                     in_ch,
  lsrd_out_if.source                  out_ch
);
  import lsrd_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               match_r, match_nxt;
  logic               half_r, half_nxt;
  logic [5:0]         high_r, high_nxt;
  logic [STEP_W-1:0]  count_r, count_nxt;

  logic               ovalid_r, ovalid_nxt;
  kind_t              kind_r, kind_nxt;
  logic [STEP_W-1:0]  slot_r, slot_nxt;
  logic [RANGE_W-1:0] range_r, range_nxt;
  logic [STEP_W-1:0]  filled_r, filled_nxt;

  logic               accept;
  logic [7:0]         b;
  logic               eol;
  logic [7:0]         upper;
  logic [LEN_W-1:0]   len_inc;
  logic [LEN_W-1:0]   e1, e2, elen;
  logic [LEN_W-1:0]   di;
  logic [7:0]         echo_ch;
  logic [5:0]         low;
  logic [11:0]        raw;

  assign in_ch.ready = !hold && (!ovalid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;
  assign eol         = (b == CHAR_CR) || (b == CHAR_LF);
  assign upper       = (b >= CHAR_LOW_A && b <= CHAR_LOW_Z) ? b - CASE_DIFF : b;
  assign len_inc     = (len_r == LEN_MAX) ? len_r : len_r + 4'd1;
  assign low         = 6'(b - CHAR_ZERO);
  assign raw         = {high_r, low};

  // Field lengths grow by one digit when the value needs it.
  assign e1   = 4'd4 + 4'(echo_cfg.start_d[3] != 4'd0);
  assign e2   = e1 + 4'd3 + 4'(echo_cfg.end_d[3] != 4'd0);
  assign elen = e2 + 4'd2 + 4'(echo_cfg.clu_d[2] != 4'd0);

  always_comb begin
    di      = '0;
    echo_ch = CHAR_G;
    if (len_r == '0) begin
      echo_ch = CHAR_G;
    end else if (len_r < e1) begin
      di      = e1 - 4'd1 - len_r;
      echo_ch = {4'h3, echo_cfg.start_d[di[1:0]]};
    end else if (len_r < e2) begin
      di      = e2 - 4'd1 - len_r;
      echo_ch = {4'h3, echo_cfg.end_d[di[1:0]]};
    end else begin
      di      = elen - 4'd1 - len_r;
      echo_ch = {4'h3, echo_cfg.clu_d[di[1:0]]};
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    len_nxt    = len_r;
    match_nxt  = match_r;
    half_nxt   = half_r;
    high_nxt   = high_r;
    count_nxt  = count_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    kind_nxt   = kind_r;
    slot_nxt   = slot_r;
    range_nxt  = range_r;
    filled_nxt = filled_r;
    if (accept) begin
      unique case (phase_r)
        PH_DATA: begin
          if (eol) begin
            len_nxt   = '0;
            match_nxt = 1'b1;
            if (len_r == '0) begin
              ovalid_nxt = 1'b1;
              kind_nxt   = KIND_DONE;
              slot_nxt   = '0;
              range_nxt  = '0;
              filled_nxt = count_r;
              phase_nxt  = PH_ECHO;
              half_nxt   = 1'b0;
            end
          end else begin
            len_nxt = len_inc;
            if (!half_r) begin
              high_nxt = low;
              half_nxt = 1'b1;
            end else begin
              half_nxt = 1'b0;
              if (count_r < slot_total) begin
                ovalid_nxt = 1'b1;
                kind_nxt   = KIND_RANGE;
                slot_nxt   = slot_total - 10'd1 - count_r;
                range_nxt  = (raw < RANGE_MIN) ? RANGE_NONE : {1'b0, raw};
                filled_nxt = '0;
                count_nxt  = count_r + 10'd1;
              end
            end
          end
        end
        PH_STATUS: begin
          if (eol) begin
            len_nxt   = '0;
            match_nxt = 1'b1;
            if (match_r && len_r == 4'd1) begin
              phase_nxt = PH_DATA;
              count_nxt = '0;
              half_nxt  = 1'b0;
              high_nxt  = '0;
            end else begin
              phase_nxt  = PH_ECHO;
              ovalid_nxt = 1'b1;
              kind_nxt   = KIND_STATUS_ERR;
              slot_nxt   = '0;
              range_nxt  = '0;
              filled_nxt = '0;
            end
          end else begin
            if (len_r != '0 || b != CHAR_ZERO) begin
              match_nxt = 1'b0;
            end
            len_nxt = len_inc;
          end
        end
        default: begin
          phase_nxt = PH_ECHO;
          if (eol) begin
            len_nxt   = '0;
            match_nxt = 1'b1;
            if (match_r && len_r == elen) begin
              phase_nxt = PH_STATUS;
            end else begin
              ovalid_nxt = 1'b1;
              kind_nxt   = KIND_ECHO_ERR;
              slot_nxt   = '0;
              range_nxt  = '0;
              filled_nxt = '0;
            end
          end else begin
            if (len_r >= elen || upper != echo_ch) begin
              match_nxt = 1'b0;
            end
            len_nxt = len_inc;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_ECHO;
      len_r    <= '0;
      match_r  <= 1'b1;
      half_r   <= 1'b0;
      high_r   <= '0;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      len_r    <= len_nxt;
      match_r  <= match_nxt;
      half_r   <= half_nxt;
      high_r   <= high_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    slot_r   <= slot_nxt;
    range_r  <= range_nxt;
    filled_r <= filled_nxt;
  end

  assign out_ch.valid           = ovalid_r;
  assign out_ch.kind            = kind_r;
  assign out_ch.slot            = slot_r;
  assign out_ch.range_mm        = range_r;
  assign out_ch.readings_filled = filled_r;

endmodule

// ===== design/laser_scan_reply_decoder.sv =====
// Decodes a rangefinder's reply to a distance request, one received character per
// request on in_ch, and delivers range readings, scan-complete, echo-mismatch and
// bad-status results on out_ch through a single result register. A new character is
// taken every cycle as long as results are taken; a result that is not taken holds
// off the input until it leaves. After reset and after every write to the start-step,
// end-step or cluster-count register the input is held off while the number of reading
// slots is recomputed by an 11-bit restoring divider that produces one quotient bit a
// cycle; input is also held off in the cycle of a register write.
module laser_scan_reply_decoder #(
  parameter int unsigned MAX_STEP = lsrd_pkg::MAX_STEP_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lsrd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lsrd_pkg::STEP_W-1:0]    cfg_wdata,
  lsrd_in_if.sink                        in_ch,
  lsrd_out_if.source                     out_ch
);
  import lsrd_pkg::*;

  logic [STEP_W-1:0] start_step, end_step, slot_total;
  logic [CLU_W-1:0]  cluster_count;
  echo_cfg_t         echo_cfg;
  logic              kick, div_busy, hold;

  lsrd_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .start_step    (start_step),
    .end_step      (end_step),
    .cluster_count (cluster_count),
    .echo_cfg      (echo_cfg),
    .kick          (kick)
  );

  lsrd_div #(
    .MAX_STEP (MAX_STEP)
  ) u_div (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (kick),
    .start_step    (start_step),
    .end_step      (end_step),
    .cluster_count (cluster_count),
    .busy          (div_busy),
    .slot_total    (slot_total)
  );

  assign hold = kick || div_busy || cfg_we;

  lsrd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .hold       (hold),
    .echo_cfg   (echo_cfg),
    .slot_total (slot_total),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

endmodule
